// ===== rtl/slr_pkg.sv =====
package slr_pkg;
   localparam int MAX_SCALE_DEF   = 8;
   localparam int COORD_BITS_DEF  = 16;
   localparam int SCREEN_BITS_DEF = 12;

   localparam logic [2:0] OP_MOVE    = 3'd0;
   localparam logic [2:0] OP_PLOT    = 3'd1;
   localparam logic [2:0] OP_LINE    = 3'd2;
   localparam logic [2:0] OP_FILL    = 3'd3;
   localparam logic [2:0] OP_ADVANCE = 3'd4;

   localparam logic [2:0] REG_SCALE   = 3'd0;
   localparam logic [2:0] REG_VWIDTH  = 3'd1;
   localparam logic [2:0] REG_VHEIGHT = 3'd2;
   localparam logic [2:0] REG_SWIDTH  = 3'd3;
   localparam logic [2:0] REG_SHEIGHT = 3'd4;
   localparam logic [2:0] REG_PITCH   = 3'd5;
   localparam logic [2:0] REG_HOFF    = 3'd6;
   localparam logic [2:0] REG_VOFF    = 3'd7;

   // One virtual pixel job handed from the front part to the back part.
   typedef struct packed {
      logic        idle;      // idle advance: one all-zero result
      logic        in_area;   // pixel lies in the virtual area
      logic [12:0] vx;
      logic [12:0] vy;
      logic [23:0] color;
      logic        done;
   } pix_job_type;
endpackage

// ===== rtl/slr_front.sv =====
module slr_front
   import slr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_operation,
   input  logic signed [COORD_BITS-1:0] req_target_x,
   input  logic signed [COORD_BITS-1:0] req_target_y,
   input  logic [23:0]                  req_pen_color,
   input  logic [12:0]                  virtual_width,
   input  logic [12:0]                  virtual_height,
   output logic                         job_valid,
   input  logic                         job_stall,
   output pix_job_type                  job
);
   localparam int CB = COORD_BITS;
   typedef enum logic [1:0] {KIND_IDLE, KIND_LINE, KIND_FILL} kind_type;

   kind_type            kind_ff, kind_in;
   logic signed [CB-1:0] pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   logic signed [CB-1:0] walk_x_ff, walk_x_in, walk_y_ff, walk_y_in;
   logic signed [CB-1:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic signed [CB-1:0] left_ff, left_in;
   logic signed [CB:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [1:0]           signs_ff, signs_in;
   logic signed [CB+2:0] err_ff, err_in;
   logic [23:0]          color_ff, color_in;
   logic                 jv_ff, jv_in;
   pix_job_type          job_ff, job_in;

   logic                 accept, emit;
   logic signed [CB-1:0] px, py;
   logic                 fin;
   logic signed [CB:0]   ddx, ddy;
   logic signed [CB+2:0] e2;

   assign req_stall = jv_ff && job_stall;
   assign accept    = req_valid && !req_stall;
   assign job_valid = jv_ff;
   assign job       = job_ff;

   always_comb begin
      kind_in = kind_ff; pen_x_in = pen_x_ff; pen_y_in = pen_y_ff;
      walk_x_in = walk_x_ff; walk_y_in = walk_y_ff;
      goal_x_in = goal_x_ff; goal_y_in = goal_y_ff; left_in = left_ff;
      dx_in = dx_ff; dy_in = dy_ff; signs_in = signs_ff; err_in = err_ff;
      color_in = color_ff;
      jv_in = jv_ff && job_stall;
      job_in = job_ff;
      emit = 1'b0;
      px = req_target_x; py = req_target_y;
      fin = (walk_x_ff == goal_x_ff) && (walk_y_ff == goal_y_ff);
      ddx = {req_target_x[CB-1], req_target_x} - {pen_x_ff[CB-1], pen_x_ff};
      ddy = {req_target_y[CB-1], req_target_y} - {pen_y_ff[CB-1], pen_y_ff};
      e2 = err_ff <<< 1;
      if (accept) begin
         job_in.idle = 1'b0;
         job_in.done = 1'b0;
         job_in.color = color_ff;
         case (req_operation)
            OP_MOVE: begin
               pen_x_in = req_target_x; pen_y_in = req_target_y;
            end
            OP_PLOT: begin
               kind_in = KIND_IDLE; color_in = req_pen_color;
               pen_x_in = req_target_x; pen_y_in = req_target_y;
               job_in.color = req_pen_color;
               emit = 1'b1;
            end
            OP_LINE: begin
               signs_in = {!(ddy > 0), !(ddx > 0)};
               dx_in = (ddx < 0) ? -ddx : ddx;
               dy_in = (ddy < 0) ? -ddy : ddy;
               err_in = (CB+3)'(dx_in) - (CB+3)'(dy_in);
               walk_x_in = pen_x_ff; walk_y_in = pen_y_ff;
               goal_x_in = req_target_x; goal_y_in = req_target_y;
               color_in = req_pen_color; kind_in = KIND_LINE;
               pen_x_in = req_target_x; pen_y_in = req_target_y;
            end
            OP_FILL: begin
               left_in   = (pen_x_ff < req_target_x) ? pen_x_ff : req_target_x;
               goal_x_in = (pen_x_ff > req_target_x) ? pen_x_ff : req_target_x;
               walk_y_in = (pen_y_ff < req_target_y) ? pen_y_ff : req_target_y;
               goal_y_in = (pen_y_ff > req_target_y) ? pen_y_ff : req_target_y;
               walk_x_in = left_in;
               color_in = req_pen_color; kind_in = KIND_FILL;
               pen_x_in = req_target_x; pen_y_in = req_target_y;
            end
            OP_ADVANCE: begin
               emit = 1'b1;
               if (kind_ff == KIND_IDLE) begin
                  job_in.idle = 1'b1;
               end else begin
                  px = walk_x_ff; py = walk_y_ff;
                  job_in.done = fin;
                  if (fin) begin
                     kind_in = KIND_IDLE;
                  end else if (kind_ff == KIND_LINE) begin
                     err_in = err_ff;
                     if (e2 > -(CB+3)'(dy_ff)) begin
                        err_in = err_in - (CB+3)'(dy_ff);
                        walk_x_in = signs_ff[0] ? walk_x_ff - 1'b1 : walk_x_ff + 1'b1;
                     end
                     if (e2 < (CB+3)'(dx_ff)) begin
                        err_in = err_in + (CB+3)'(dx_ff);
                        walk_y_in = signs_ff[1] ? walk_y_ff - 1'b1 : walk_y_ff + 1'b1;
                     end
                  end else if (walk_x_ff == goal_x_ff) begin
                     walk_x_in = left_ff;
                     walk_y_in = walk_y_ff + 1'b1;
                  end else begin
                     walk_x_in = walk_x_ff + 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
      if (emit) begin
         jv_in = 1'b1;
         job_in.in_area = !px[CB-1] && !py[CB-1]
                          && ({{(32-CB){1'b0}}, px} < {19'd0, virtual_width})
                          && ({{(32-CB){1'b0}}, py} < {19'd0, virtual_height});
         job_in.vx = 13'(px);
         job_in.vy = 13'(py);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_IDLE; pen_x_ff <= '0; pen_y_ff <= '0;
         walk_x_ff <= '0; walk_y_ff <= '0; goal_x_ff <= '0; goal_y_ff <= '0;
         left_ff <= '0; dx_ff <= '0; dy_ff <= '0; signs_ff <= '0; err_ff <= '0;
         color_ff <= '0; jv_ff <= 1'b0;
      end else begin
         kind_ff <= kind_in; pen_x_ff <= pen_x_in; pen_y_ff <= pen_y_in;
         walk_x_ff <= walk_x_in; walk_y_ff <= walk_y_in;
         goal_x_ff <= goal_x_in; goal_y_ff <= goal_y_in; left_ff <= left_in;
         dx_ff <= dx_in; dy_ff <= dy_in; signs_ff <= signs_in; err_ff <= err_in;
         color_ff <= color_in; jv_ff <= jv_in;
      end
      job_ff <= job_in;
   end
endmodule

// ===== rtl/slr_back.sv =====
module slr_back
   import slr_pkg::*;
#(
   parameter int MAX_SCALE   = MAX_SCALE_DEF,
   parameter int SCREEN_BITS = SCREEN_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   output logic        job_stall,
   input  pix_job_type job,
   input  logic [3:0]  scale_factor,
   input  logic [12:0] screen_width,
   input  logic [12:0] screen_height,
   input  logic [14:0] row_pitch,
   input  logic [11:0] horiz_offset,
   input  logic [11:0] vert_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_write_valid,
   output logic [11:0] rsp_phys_x,
   output logic [11:0] rsp_phys_y,
   output logic [25:0] rsp_byte_offset,
   output logic [23:0] rsp_pixel_value,
   output logic        rsp_last_write,
   output logic        rsp_primitive_done
);
   localparam logic [13:0] LIM = 14'(1) << SCREEN_BITS;
   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type   state_ff;
   pix_job_type cur_ff;
   logic [3:0]  s_ff, i_ff, j_ff;
   logic [25:0] x0_ff, y0_ff;
   logic        ov_ff;
   logic        w_ff, l_ff, d_ff;
   logic [11:0] x_ff, yy_ff;
   logic [25:0] off_ff;
   logic [23:0] c_ff;

   logic [3:0]  s_eff;
   logic [13:0] sw, sh;
   logic [25:0] px, py;
   logic        keep, last, out_free;

   always_comb begin
      s_eff = scale_factor;
      if (s_eff == 4'd0) s_eff = 4'd1;
      if (s_eff > 4'(MAX_SCALE)) s_eff = 4'(MAX_SCALE);
      sw = ({1'b0, screen_width} < LIM) ? {1'b0, screen_width} : LIM;
      sh = ({1'b0, screen_height} < LIM) ? {1'b0, screen_height} : LIM;
      px = x0_ff + 26'(j_ff);
      py = y0_ff + 26'(i_ff);
      keep = cur_ff.in_area && !cur_ff.idle && (px < 26'(sw)) && (py < 26'(sh));
      last = !cur_ff.in_area || cur_ff.idle
             || ((i_ff == s_ff - 4'd1) && (j_ff == s_ff - 4'd1));
   end

   assign out_free  = !ov_ff || !rsp_stall;
   assign job_stall = (state_ff == ST_RUN);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; ov_ff <= 1'b0;
      end else begin
         ov_ff <= (ov_ff && rsp_stall) || ((state_ff == ST_RUN) && out_free);
         case (state_ff)
            ST_IDLE: if (job_valid) begin
               cur_ff <= job;
               s_ff <= s_eff; i_ff <= '0; j_ff <= '0;
               x0_ff <= 26'(horiz_offset) + 26'(job.vx) * 26'(s_eff);
               y0_ff <= 26'(vert_offset) + 26'(job.vy) * 26'(s_eff);
               state_ff <= ST_RUN;
            end
            ST_RUN: if (out_free) begin
               w_ff <= keep;
               x_ff <= keep ? 12'(px) : '0;
               yy_ff <= keep ? 12'(py) : '0;
               off_ff <= keep ? 26'(py * 26'(row_pitch) + (px << 2)) : '0;
               c_ff <= keep ? cur_ff.color : '0;
               l_ff <= last;
               d_ff <= cur_ff.done;
               if (last) state_ff <= ST_IDLE;
               else if (j_ff == s_ff - 4'd1) begin
                  j_ff <= '0; i_ff <= i_ff + 4'd1;
               end else j_ff <= j_ff + 4'd1;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid          = ov_ff;
   assign rsp_write_valid    = w_ff;
   assign rsp_phys_x         = x_ff;
   assign rsp_phys_y         = yy_ff;
   assign rsp_byte_offset    = off_ff;
   assign rsp_pixel_value    = c_ff;
   assign rsp_last_write     = l_ff;
   assign rsp_primitive_done = d_ff;
endmodule

// ===== rtl/scaled_line_rect_rasterizer.sv =====
// Channel   | valid / stall           | payload
// req       | req_valid / req_stall   | operation, target_x, target_y, pen_color
// rsp       | rsp_valid / rsp_stall   | write_valid .. primitive_done
// csr       | APB psel/penable        | eight registers at 4*i
// A plot or advance emits scale*scale results (one for a dropped pixel or an
// idle advance), one a cycle while rsp_stall is low; the first passes through
// the front's job register and then the back's job load. Each job costs the
// back a load step on top of its results; move/line/fill emit no result.
// Reset (synchronous, active high) restores register defaults and idles the pen.
// The front takes commands unless the one-entry job register is full and the
// back busy; rsp_stall holds the back sequencer and, through it, the front.
module scaled_line_rect_rasterizer
   import slr_pkg::*;
#(
   parameter int MAX_SCALE   = MAX_SCALE_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF,
   parameter int SCREEN_BITS = SCREEN_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_operation,
   input  logic signed [COORD_BITS-1:0] req_target_x,
   input  logic signed [COORD_BITS-1:0] req_target_y,
   input  logic [23:0]                  req_pen_color,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_write_valid,
   output logic [11:0]                  rsp_phys_x,
   output logic [11:0]                  rsp_phys_y,
   output logic [25:0]                  rsp_byte_offset,
   output logic [23:0]                  rsp_pixel_value,
   output logic                         rsp_last_write,
   output logic                         rsp_primitive_done,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [4:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   logic [3:0]  scale_ff;
   logic [12:0] vw_ff, vh_ff, sw_ff, sh_ff;
   logic [14:0] pitch_ff;
   logic [11:0] hoff_ff, voff_ff;
   logic        job_valid, job_stall;
   pix_job_type job;
   logic [2:0]  reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];

   // Write registers on the access cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= 4'd1; vw_ff <= 13'd640; vh_ff <= 13'd480;
         sw_ff <= 13'd640; sh_ff <= 13'd480; pitch_ff <= 15'd2560;
         hoff_ff <= '0; voff_ff <= '0;
      end else if (psel && penable && pwrite) begin
         case (reg_idx)
            REG_SCALE:   scale_ff <= pwdata[3:0];
            REG_VWIDTH:  vw_ff <= pwdata[12:0];
            REG_VHEIGHT: vh_ff <= pwdata[12:0];
            REG_SWIDTH:  sw_ff <= pwdata[12:0];
            REG_SHEIGHT: sh_ff <= pwdata[12:0];
            REG_PITCH:   pitch_ff <= pwdata[14:0];
            REG_HOFF:    hoff_ff <= pwdata[11:0];
            REG_VOFF:    voff_ff <= pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SCALE:   prdata = {28'd0, scale_ff};
         REG_VWIDTH:  prdata = {19'd0, vw_ff};
         REG_VHEIGHT: prdata = {19'd0, vh_ff};
         REG_SWIDTH:  prdata = {19'd0, sw_ff};
         REG_SHEIGHT: prdata = {19'd0, sh_ff};
         REG_PITCH:   prdata = {17'd0, pitch_ff};
         REG_HOFF:    prdata = {20'd0, hoff_ff};
         REG_VOFF:    prdata = {20'd0, voff_ff};
         default:     prdata = '0;
      endcase
   end

   slr_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_operation, .req_target_x,
      .req_target_y, .req_pen_color, .virtual_width(vw_ff),
      .virtual_height(vh_ff), .job_valid, .job_stall, .job
   );

   slr_back #(.MAX_SCALE(MAX_SCALE), .SCREEN_BITS(SCREEN_BITS)) u_back (
      .clock, .reset, .job_valid, .job_stall, .job, .scale_factor(scale_ff),
      .screen_width(sw_ff), .screen_height(sh_ff), .row_pitch(pitch_ff),
      .horiz_offset(hoff_ff), .vert_offset(voff_ff), .rsp_valid, .rsp_stall,
      .rsp_write_valid, .rsp_phys_x, .rsp_phys_y, .rsp_byte_offset,
      .rsp_pixel_value, .rsp_last_write, .rsp_primitive_done
   );

`ifndef ASSERT_OFF
   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_valid |-> rsp_byte_offset == 26'd0 && rsp_pixel_value == 24'd0)
      else $error("clipped result carries data");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped under stall");
`endif
endmodule
